### design/hcaws_pkg.sv
// shared types and constants for the checked atomic word store
package hcaws_pkg;
  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned WordsDefault = 64;

  localparam logic [3:0] OpCreate  = 4'd0;
  localparam logic [3:0] OpDestroy = 4'd1;
  localparam logic [3:0] OpFill    = 4'd2;
  localparam logic [3:0] OpLoad    = 4'd3;
  localparam logic [3:0] OpStore   = 4'd4;
  localparam logic [3:0] OpXchg    = 4'd5;
  localparam logic [3:0] OpCas     = 4'd6;
  localparam logic [3:0] OpAdd     = 4'd7;
  localparam logic [3:0] OpSub     = 4'd8;
  localparam logic [3:0] OpAnd     = 4'd9;
  localparam logic [3:0] OpOr      = 4'd10;
  localparam logic [3:0] OpXor     = 4'd11;
  localparam logic [3:0] OpQuery   = 4'd12;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StInvalid  = 2'd2;
  localparam logic [1:0] StNoSlot   = 2'd3;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [31:0] handle_slot;
    logic [31:0] handle_generation;
    logic [15:0] word_count;
    logic [15:0] word_index;
    logic [63:0] operand_value;
    logic [63:0] compare_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  new_slot;
    logic [31:0] new_generation;
    logic [63:0] old_word;
    logic [6:0]  buffer_length;
    logic        swap_done;
  } rsp_t;

  // word alu for the read-modify-write operations
  function automatic logic [63:0] word_alu(input logic [3:0] op, input logic [63:0] cur,
                                           input logic [63:0] val, input logic [63:0] cmp);
    logic [63:0] r;
    r = cur;
    case (op)
      OpStore, OpXchg: r = val;
      OpCas:           r = (cur == cmp) ? val : cur;
      OpAdd:           r = cur + val;
      OpSub:           r = cur - val;
      OpAnd:           r = cur & val;
      OpOr:            r = cur | val;
      OpXor:           r = cur ^ val;
      default:         r = cur;
    endcase
    return r;
  endfunction
endpackage

### design/hcaws_if.sv
// valid/ready channel carrying one word of a given payload type
interface hcaws_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/hcaws_word_ram.sv
// word memory, one write port and one registered read port
module hcaws_word_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [63:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [63:0]      rdata_o
);
  logic [63:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### design/handle_checked_atomic_word_store.sv
// Checked atomic word store: SLOTS buffers of up to WORDS_PER_SLOT 64-bit words held in one
// single-port-read word memory, addressed by slot/generation handles. Load, store and the
// read-modify-write operations pass through accept and read, modify and write back, and the
// result register; query, destroy and failed requests go from acceptance straight to the
// result register; create and fill first walk the slot's words through the memory write
// port. Slot metadata (busy, generation, length) and the free stack sit in flip-flops. One
// word is worked at a time; the result sits in an output register, and the next word is
// accepted once the store is idle and that register is free or being taken.
module handle_checked_atomic_word_store #(
  parameter int unsigned SLOTS          = hcaws_pkg::SlotsDefault,
  parameter int unsigned WORDS_PER_SLOT = hcaws_pkg::WordsDefault
) (
  input logic clk_i,
  input logic rst_ni,
  hcaws_if.sink   req_i,
  hcaws_if.source rsp_o
);
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned WW = (WORDS_PER_SLOT > 1) ? $clog2(WORDS_PER_SLOT) : 1;
  localparam int unsigned AW = SW + WW;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned LW = $clog2(WORDS_PER_SLOT + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RMW  = 4'b0010,
    S_WALK = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  hcaws_pkg::req_t req_q;
  hcaws_pkg::rsp_t rsp_q, rsp_d, res_q, res_d;
  logic rsp_valid_q, rsp_valid_d;

  logic [SLOTS-1:0] busy_q, busy_d;
  logic [31:0]      gen_q [SLOTS];
  logic [31:0]      gen_d [SLOTS];
  logic [LW-1:0]    len_q [SLOTS];
  logic [LW-1:0]    len_d [SLOTS];
  logic [SW-1:0]    stack_q [SLOTS];
  logic [SW-1:0]    stack_d [SLOTS];
  logic [CW-1:0]    free_q, free_d, made_q, made_d;

  // walk / rmw context
  logic [SW-1:0] slot_q, slot_d;
  logic [LW-1:0] idx_q, idx_d, end_q, end_d;
  logic [63:0]   fillv_q, fillv_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;

  hcaws_word_ram #(.Depth(SLOTS * WORDS_PER_SLOT), .AddrW(AW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] s, input logic [LW-1:0] i);
    logic [AW-1:0] a;
    a = AW'(s) * AW'(WORDS_PER_SLOT) + AW'(i);
    return a;
  endfunction

  // accept a new word only when idle and the output register frees up
  logic out_free;
  assign out_free   = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // handle lookup on the incoming word
  hcaws_pkg::req_t rq;
  logic [SW-1:0]   hs;
  logic            found, slot_ok;
  logic [LW-1:0]   hlen;
  assign rq = req_i.data;
  assign hs = rq.handle_slot[SW-1:0];
  assign slot_ok = (rq.handle_slot < 32'(made_q)) && (rq.handle_slot < 32'(SLOTS));
  assign found = !(rq.handle_slot == '0 && rq.handle_generation == '0) && slot_ok &&
                 busy_q[hs] && (gen_q[hs] == rq.handle_generation);
  assign hlen = len_q[hs];

  always_comb begin
    logic [SW-1:0] s;
    logic [CW-1:0] fc;
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d       = rsp_q;
    res_d       = res_q;
    busy_d = busy_q; gen_d = gen_q; len_d = len_q; stack_d = stack_q;
    free_d = free_q; made_d = made_q;
    slot_d = slot_q; idx_d = idx_q; end_d = end_q; fillv_d = fillv_q;
    we = 1'b0;
    waddr = addr_of(slot_q, idx_q);
    wdata = fillv_q;
    raddr = addr_of(hs, rq.word_index[LW-1:0]);
    s  = '0;
    fc = '0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid && req_i.ready) begin
          res_d = '0;
          if (rq.req_type == hcaws_pkg::OpCreate) begin
            if (rq.word_count == '0 || 32'(rq.word_count) > 32'(WORDS_PER_SLOT)) begin
              res_d.status = hcaws_pkg::StInvalid;
              state_d = S_DONE;
            end else if (free_q != '0) begin
              fc = free_q - CW'(1);
              free_d = fc;
              s = stack_q[fc[SW-1:0]];
              gen_d[s] = gen_q[s] + 32'd1;
              busy_d[s] = 1'b1;
              len_d[s] = LW'(rq.word_count);
              res_d.new_slot = 4'(s);
              res_d.new_generation = gen_q[s] + 32'd1;
              slot_d = s; idx_d = '0; end_d = LW'(rq.word_count); fillv_d = '0;
              state_d = S_WALK;
            end else if (made_q < CW'(SLOTS)) begin
              s = made_q[SW-1:0];
              made_d = made_q + CW'(1);
              gen_d[s] = 32'd1;
              busy_d[s] = 1'b1;
              len_d[s] = LW'(rq.word_count);
              res_d.new_slot = 4'(s);
              res_d.new_generation = 32'd1;
              slot_d = s; idx_d = '0; end_d = LW'(rq.word_count); fillv_d = '0;
              state_d = S_WALK;
            end else begin
              res_d.status = hcaws_pkg::StNoSlot;
              state_d = S_DONE;
            end
          end else if (rq.req_type > hcaws_pkg::OpQuery) begin
            res_d.status = hcaws_pkg::StInvalid;
            state_d = S_DONE;
          end else if (!found) begin
            res_d.status = hcaws_pkg::StNotFound;
            state_d = S_DONE;
          end else if (rq.req_type == hcaws_pkg::OpDestroy) begin
            busy_d[hs] = 1'b0;
            gen_d[hs] = gen_q[hs] + 32'd1;
            len_d[hs] = '0;
            if (free_q < CW'(SLOTS)) begin
              stack_d[free_q[SW-1:0]] = hs;
              free_d = free_q + CW'(1);
            end
            state_d = S_DONE;
          end else if (rq.req_type == hcaws_pkg::OpFill) begin
            slot_d = hs; idx_d = '0; end_d = hlen; fillv_d = rq.operand_value;
            state_d = S_WALK;
          end else if (rq.req_type == hcaws_pkg::OpQuery) begin
            res_d.buffer_length = 7'(hlen);
            state_d = S_DONE;
          end else if (32'(rq.word_index) >= 32'(hlen)) begin
            res_d.status = hcaws_pkg::StInvalid;
            state_d = S_DONE;
          end else begin
            // memory read issued this cycle, modify next cycle
            slot_d = hs; idx_d = rq.word_index[LW-1:0];
            state_d = S_RMW;
          end
        end
      end
      S_RMW: begin
        // registered read data is back: modify and write to the same entry
        if (req_q.req_type != hcaws_pkg::OpStore) begin
          res_d.old_word = rdata;
        end
        if (req_q.req_type == hcaws_pkg::OpCas) begin
          res_d.swap_done = (rdata == req_q.compare_value);
        end
        we = (req_q.req_type != hcaws_pkg::OpLoad);
        wdata = hcaws_pkg::word_alu(req_q.req_type, rdata, req_q.operand_value,
                                    req_q.compare_value);
        state_d = S_DONE;
      end
      S_WALK: begin
        // one word of the buffer written per cycle
        if (idx_q == end_q) begin
          state_d = S_DONE;
        end else begin
          we = 1'b1;
          idx_d = idx_q + LW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          rsp_d = res_q;
          rsp_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      busy_q      <= '0;
      free_q      <= '0;
      made_q      <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        gen_q[i] <= '0;
        len_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      busy_q      <= busy_d;
      free_q      <= free_d;
      made_q      <= made_d;
      gen_q       <= gen_d;
      len_q       <= len_d;
    end
  end

  // payload and context registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q <= rq;
    end
    rsp_q   <= rsp_d;
    res_q   <= res_d;
    stack_q <= stack_d;
    slot_q  <= slot_d;
    idx_q   <= idx_d;
    end_q   <= end_d;
    fillv_q <= fillv_d;
  end
endmodule

### sim/testbench.sv
// self-checking testbench for the checked atomic word store
module testbench;
  localparam int unsigned NumSlots = 16;
  localparam int unsigned NumWords = 64;
  localparam int unsigned MaxShown = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hcaws_if #(.T(hcaws_pkg::req_t)) req_ch ();
  hcaws_if #(.T(hcaws_pkg::rsp_t)) rsp_ch ();

  handle_checked_atomic_word_store #(
    .SLOTS(NumSlots),
    .WORDS_PER_SLOT(NumWords)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow copy of the store
  logic        sh_busy [NumSlots];
  logic [31:0] sh_gen  [NumSlots];
  logic [6:0]  sh_len  [NumSlots];
  logic [63:0] sh_mem  [NumSlots][NumWords];
  logic [3:0]  sh_free [NumSlots];
  int unsigned sh_free_cnt;
  int unsigned sh_made;

  hcaws_pkg::rsp_t pending_rsps[$];
  int unsigned mismatches;
  bit idle_on;

  // handles the random part works from
  logic [31:0] live_slot[$];
  logic [31:0] live_gen[$];

  function automatic hcaws_pkg::rsp_t predict_word(input hcaws_pkg::req_t rq);
    hcaws_pkg::rsp_t r;
    int   s;
    int unsigned n;
    logic [63:0] cur;
    r = '0;
    r.status = hcaws_pkg::StOk;
    if (rq.req_type == hcaws_pkg::OpCreate) begin
      if (rq.word_count == 0 || rq.word_count > NumWords) begin
        r.status = hcaws_pkg::StInvalid;
      end else begin
        s = -1;
        if (sh_free_cnt > 0) begin
          sh_free_cnt--;
          s = sh_free[sh_free_cnt];
          sh_gen[s] = sh_gen[s] + 32'd1;
        end else if (sh_made < NumSlots) begin
          s = sh_made;
          sh_made++;
          sh_gen[s] = 32'd1;
        end else begin
          r.status = hcaws_pkg::StNoSlot;
        end
        if (s >= 0) begin
          sh_busy[s] = 1'b1;
          sh_len[s] = rq.word_count[6:0];
          for (n = 0; n < rq.word_count; n++) sh_mem[s][n] = '0;
          r.new_slot = s[3:0];
          r.new_generation = sh_gen[s];
        end
      end
    end else if (rq.req_type <= hcaws_pkg::OpQuery) begin
      // handle lookup: zero handle, never made, free or stale all miss
      if ((rq.handle_slot == 0 && rq.handle_generation == 0) ||
          rq.handle_slot >= sh_made || !sh_busy[rq.handle_slot[3:0]] ||
          sh_gen[rq.handle_slot[3:0]] != rq.handle_generation) begin
        r.status = hcaws_pkg::StNotFound;
      end else begin
        s = rq.handle_slot[3:0];
        if (rq.req_type == hcaws_pkg::OpDestroy) begin
          sh_busy[s] = 1'b0;
          sh_gen[s] = sh_gen[s] + 32'd1;
          sh_len[s] = '0;
          if (sh_free_cnt < NumSlots) begin
            sh_free[sh_free_cnt] = s[3:0];
            sh_free_cnt++;
          end
        end else if (rq.req_type == hcaws_pkg::OpFill) begin
          for (n = 0; n < sh_len[s]; n++) sh_mem[s][n] = rq.operand_value;
        end else if (rq.req_type == hcaws_pkg::OpQuery) begin
          r.buffer_length = sh_len[s];
        end else if (rq.word_index >= sh_len[s]) begin
          r.status = hcaws_pkg::StInvalid;
        end else begin
          cur = sh_mem[s][rq.word_index];
          if (rq.req_type != hcaws_pkg::OpStore) r.old_word = cur;
          case (rq.req_type)
            hcaws_pkg::OpStore, hcaws_pkg::OpXchg:
              sh_mem[s][rq.word_index] = rq.operand_value;
            hcaws_pkg::OpCas: begin
              if (cur == rq.compare_value) begin
                sh_mem[s][rq.word_index] = rq.operand_value;
                r.swap_done = 1'b1;
              end
            end
            hcaws_pkg::OpAdd: sh_mem[s][rq.word_index] = cur + rq.operand_value;
            hcaws_pkg::OpSub: sh_mem[s][rq.word_index] = cur - rq.operand_value;
            hcaws_pkg::OpAnd: sh_mem[s][rq.word_index] = cur & rq.operand_value;
            hcaws_pkg::OpOr:  sh_mem[s][rq.word_index] = cur | rq.operand_value;
            hcaws_pkg::OpXor: sh_mem[s][rq.word_index] = cur ^ rq.operand_value;
            default: ;
          endcase
        end
      end
    end else begin
      r.status = hcaws_pkg::StInvalid;
    end
    return r;
  endfunction

  // track live handles so most random traffic hits real buffers
  task automatic note_handles(input hcaws_pkg::req_t rq, input hcaws_pkg::rsp_t r);
    int k;
    if (rq.req_type == hcaws_pkg::OpCreate && r.status == hcaws_pkg::StOk) begin
      live_slot = {live_slot, {28'd0, r.new_slot}};
      live_gen  = {live_gen, r.new_generation};
    end else if (rq.req_type == hcaws_pkg::OpDestroy && r.status == hcaws_pkg::StOk) begin
      for (k = live_slot.size() - 1; k >= 0; k--) begin
        if (live_slot[k] == rq.handle_slot) begin
          live_slot.delete(k);
          live_gen.delete(k);
        end
      end
    end
  endtask

  // drive one word and wait for it to be taken; sometimes an idle burst beforehand
  task automatic send_word(input hcaws_pkg::req_t rq);
    hcaws_pkg::rsp_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    req_ch.data  <= rq;
    req_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    r = predict_word(rq);
    pending_rsps = {pending_rsps, r};
    note_handles(rq, r);
    @(negedge clk_i);
  endtask

  function automatic hcaws_pkg::req_t blank_word(input logic [3:0] op);
    hcaws_pkg::req_t rq;
    rq = '0;
    rq.req_type = op;
    return rq;
  endfunction

  function automatic hcaws_pkg::req_t on_handle(input logic [3:0] op, input logic [31:0] sl,
                                                input logic [31:0] gn, input logic [15:0] ix,
                                                input logic [63:0] val);
    hcaws_pkg::req_t rq;
    rq = blank_word(op);
    rq.handle_slot = sl;
    rq.handle_generation = gn;
    rq.word_index = ix;
    rq.operand_value = val;
    return rq;
  endfunction

  // receiver side: random stalls, check against the oldest expectation
  always @(negedge clk_i) begin
    if (!rst_ni) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= !(idle_on && $urandom_range(0, 3) == 0);
  end

  always @(posedge clk_i) begin
    hcaws_pkg::rsp_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown) $display("unexpected word %p", rsp_ch.data);
      end else begin
        want = pending_rsps.pop_front();
        if (rsp_ch.data !== want) begin
          mismatches++;
          if (mismatches <= MaxShown) begin
            $display("mismatch: expected %p", want);
            $display("          actual   %p", rsp_ch.data);
          end
        end
      end
    end
  end

  // drop valid and hold off until every expected word has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_rsps.size() != 0) @(negedge clk_i);
  endtask

  // lifecycle, bad lengths, zero handle, unknown ops and slot exhaustion
  task automatic test_lifecycle();
    hcaws_pkg::req_t rq;
    int k;
    rq = blank_word(hcaws_pkg::OpCreate); rq.word_count = 16'd0; send_word(rq);
    rq.word_count = 16'hffff;                                    send_word(rq);
    rq.word_count = 16'd65;                                      send_word(rq);
    rq.word_count = 16'd64;                                      send_word(rq);
    rq.word_count = 16'd1;                                       send_word(rq);
    send_word(on_handle(hcaws_pkg::OpLoad, 32'd0, 32'd0, 16'd0, '0));
    send_word(on_handle(hcaws_pkg::OpQuery, 32'd0, 32'd1, 16'd0, '0));
    send_word(on_handle(hcaws_pkg::OpLoad, 32'd0, 32'd1, 16'd64, '0));
    send_word(on_handle(hcaws_pkg::OpLoad, 32'd1, 32'd1, 16'hffff, '0));
    send_word(on_handle(hcaws_pkg::OpQuery, 32'hffffffff, 32'hffffffff, 16'd0, '0));
    for (k = 13; k < 16; k++) send_word(blank_word(k[3:0]));
    for (k = 0; k < 15; k++) begin
      rq = blank_word(hcaws_pkg::OpCreate); rq.word_count = 16'd2; send_word(rq);
    end
    send_word(on_handle(hcaws_pkg::OpDestroy, 32'd1, 32'd1, 16'd0, '0));
    send_word(on_handle(hcaws_pkg::OpDestroy, 32'd1, 32'd1, 16'd0, '0));
    send_word(on_handle(hcaws_pkg::OpDestroy, 32'd0, 32'd1, 16'd0, '0));
    rq = blank_word(hcaws_pkg::OpCreate); rq.word_count = 16'd3; send_word(rq);
    send_word(rq);
    send_word(on_handle(hcaws_pkg::OpQuery, 32'd1, 32'd3, 16'd0, '0));
  endtask

  // every word operation on slot 0 at its extremes
  task automatic test_word_ops();
    hcaws_pkg::req_t rq;
    int k;
    logic [31:0] g;
    g = sh_gen[0];
    send_word(on_handle(hcaws_pkg::OpFill, 32'd0, g, 16'd0, 64'h8000_0000_0000_0000));
    send_word(on_handle(hcaws_pkg::OpLoad, 32'd0, g, 16'd2, '0));
    send_word(on_handle(hcaws_pkg::OpStore, 32'd0, g, 16'd2, 64'hffff_ffff_ffff_ffff));
    for (k = hcaws_pkg::OpXchg; k <= hcaws_pkg::OpXor; k++) begin
      rq = on_handle(k[3:0], 32'd0, g, 16'd0, 64'h7fff_ffff_ffff_ffff);
      rq.compare_value = sh_mem[0][0];
      send_word(rq);
      rq.compare_value = ~sh_mem[0][0];
      send_word(rq);
    end
    send_word(on_handle(hcaws_pkg::OpAdd, 32'd0, g, 16'd1, 64'hffff_ffff_ffff_ffff));
    send_word(on_handle(hcaws_pkg::OpSub, 32'd0, g, 16'd1, 64'h1));
  endtask

  // random traffic: mostly valid handles, some stale or junk
  task automatic test_random(input int unsigned count);
    hcaws_pkg::req_t rq;
    int unsigned n, pick, sel;
    for (n = 0; n < count; n++) begin
      rq.req_type          = $urandom_range(0, 99) < 8 ? hcaws_pkg::OpCreate :
                             $urandom_range(0, 99) < 6 ? hcaws_pkg::OpDestroy :
                             $urandom_range(0, 99) < 3 ? 4'($urandom_range(13, 15)) :
                             4'($urandom_range(2, 12));
      rq.handle_slot       = $urandom;
      rq.handle_generation = $urandom;
      rq.word_count        = $urandom_range(0, 9) == 0 ? 16'($urandom) :
                             16'($urandom_range(1, 8));
      rq.word_index        = $urandom_range(0, 9) == 0 ? 16'($urandom) :
                             16'($urandom_range(0, 8));
      rq.operand_value     = {$urandom, $urandom};
      rq.compare_value     = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (pick < 8 && live_slot.size() != 0) begin
        sel = $urandom_range(0, live_slot.size() - 1);
        rq.handle_slot = live_slot[sel];
        rq.handle_generation = live_gen[sel] - 32'(pick == 7);
        if (rq.req_type == hcaws_pkg::OpCas && $urandom_range(0, 1) && rq.word_index < 64)
          rq.compare_value = sh_mem[rq.handle_slot[3:0]][rq.word_index];
      end
      // never the long fill on a big buffer in the random part is fine: at most 64
      send_word(rq);
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    mismatches   = 0;
    idle_on      = 1'b1;
    sh_free_cnt  = 0;
    sh_made      = 0;
    for (int s = 0; s < NumSlots; s++) begin
      sh_busy[s] = 1'b0;
      sh_gen[s]  = '0;
      sh_len[s]  = '0;
    end
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_lifecycle();
    test_word_ops();
    // hold off the sender until the store has answered everything
    wait_drained();
    test_random(800);
    idle_on = 1'b0;
    test_random(300);
    wait_drained();
    repeat (200) @(negedge clk_i);
    if (mismatches == 0 && pending_rsps.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("testbench: errors");
    $finish;
  end
endmodule

### handle_checked_atomic_word_store.f
design/hcaws_pkg.sv
design/hcaws_if.sv
design/hcaws_word_ram.sv
design/handle_checked_atomic_word_store.sv
sim/testbench.sv
